>>> hw/rtl/prime_trial_division_tester_unit_macros.svh
// Assertion helpers shared by the tester RTL.
`ifndef PRIME_TRIAL_DIVISION_TESTER_UNIT_MACROS_SVH
`define PRIME_TRIAL_DIVISION_TESTER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PTDT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ptdt: implication check failed");

// Next-cycle implication, off while reset is asserted.
`define PTDT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ptdt: next-cycle check failed");

`endif

>>> hw/rtl/ptdt_pkg.sv
package ptdt_pkg;

	localparam int CAND_BITS       = 32;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int FIRST_DIV       = 5;
	localparam int DIV_STEP        = 6;
	localparam int PAIR_GAP        = 2;
	localparam int SMALL_PRIME_MAX = 3;

	typedef enum logic [1:0] {
		DS_THREE = 2'd0,
		DS_D     = 2'd1,
		DS_D2    = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     sqrt_start;
		logic     sqrt_step;
		logic     div_start;
		logic     div_step;
		div_sel_t div_sel;
		logic     d_next;
	} ptdt_cmd_t;

	typedef struct packed {
		logic le1;
		logic le3;
		logic even;
		logic sqrt_last;
		logic div_last;
		logic rem_zero;
		logic past_bound;
	} ptdt_sts_t;

endpackage

>>> hw/rtl/prime_trial_division_tester_unit.sv
// Trial-division primality tester, 6k +/- 1 divisor pairs.
// Input channel s_*: one candidate per item, taken when s_tvalid and s_tready.
// Output channel m_*: one result per candidate, the value echoed in m_tdata
// and the prime flag in m_tuser.
// The value is cut to VALUE_BITS before testing and echoed as tested.
// Work per item: values below 4 and even values go straight to the output
// register; others are first divided by 3, then the square root is taken one
// root digit per step, then divisor pairs are tried, each pair after a bound
// check, until a divisor leaves no remainder or the bound is passed.
// The time is set by the shared bit-serial remainder unit: one quotient bit
// per cycle, and all divisions go through it one after another.
// One item is worked at a time; s_tready is high only while the unit is idle.
// A finished result sits in the output register; the unit already takes the
// next candidate while m_tready is low, and holds its next result until the
// register frees up.
// Reset (arst_n low) clears the controller and the output valid at once;
// nothing else needs clearing.
`include "prime_trial_division_tester_unit_macros.svh"

module prime_trial_division_tester_unit #(
	parameter int VALUE_BITS = ptdt_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ptdt_pkg::CAND_BITS-1:0] s_tdata,  // [31:0] candidate
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ptdt_pkg::CAND_BITS-1:0] m_tdata,  // [31:0] tested_value
	output logic [0:0]                     m_tuser   // [0] prime_flag
);
	import ptdt_pkg::*;

	ptdt_cmd_t             cmd;
	ptdt_sts_t             sts;
	logic                  in_fire;
	logic                  in_ready;
	logic                  out_free;
	logic                  out_load;
	logic                  out_flag;
	logic [VALUE_BITS-1:0] value;

	logic                  out_valid_q;
	logic [CAND_BITS-1:0]  out_value_q;
	logic                  out_flag_q;

	assign in_fire  = s_tvalid && in_ready;
	assign out_free = !out_valid_q || m_tready;

	ptdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready),
		.out_load (out_load),
		.out_flag (out_flag)
	);

	ptdt_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cand   (VALUE_BITS'(s_tdata)),
		.sts    (sts),
		.value  (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= CAND_BITS'(value);
			out_flag_q  <= out_flag;
		end
	end

	assign s_tready   = in_ready;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_value_q;
	assign m_tuser[0] = out_flag_q;

	`PTDT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`PTDT_ASSERT_NXT(a_result_goes_out, clk, arst_n, out_load, m_tvalid)

endmodule

>>> hw/rtl/ptdt_datapath.sv
`include "prime_trial_division_tester_unit_macros.svh"

module ptdt_datapath #(
	parameter int VALUE_BITS = ptdt_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptdt_pkg::ptdt_cmd_t   cmd,
	input  logic [VALUE_BITS-1:0] cand,
	output ptdt_pkg::ptdt_sts_t   sts,
	output logic [VALUE_BITS-1:0] value
);
	import ptdt_pkg::*;

	localparam int W    = VALUE_BITS;
	localparam int HALF = (W + 1) / 2;
	localparam int SQW  = 2 * HALF;
	localparam int DW   = HALF + 1;
	localparam int CW   = $clog2(W);

	logic [W-1:0]      v_q;
	logic [SQW-1:0]    sv_q;
	logic [HALF-1:0]   root_q;
	logic [HALF+1:0]   srem_q;
	logic [DW-1:0]     d_q;
	logic [W-1:0]      dd_q;
	logic [W:0]        r_q;
	logic [W-1:0]      dvs_q;
	logic [CW-1:0]     cnt_q;

	logic [HALF+1:0]   sq_sh;
	logic [HALF+1:0]   sq_trial;
	logic              sq_ge;
	logic [W:0]        r_sh;
	logic              r_ge;
	logic [DW-1:0]     d2;
	logic [W-1:0]      dsel;

	// one root digit per step: bring down two bits, try 4*root+1
	assign sq_sh    = {srem_q[HALF-1:0], sv_q[SQW-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;

	// restoring remainder, one dividend bit per step
	assign r_sh = {r_q[W-1:0], dd_q[W-1]};
	assign r_ge = r_sh >= {1'b0, dvs_q};

	assign d2 = d_q + DW'(PAIR_GAP);

	always_comb begin
		case (cmd.div_sel)
			DS_THREE: dsel = W'(SMALL_PRIME_MAX);
			DS_D:     dsel = W'(d_q);
			DS_D2:    dsel = W'(d2);
			default:  dsel = W'(d_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.sqrt_start || cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.sqrt_step || cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= cand;
			d_q <= DW'(FIRST_DIV);
		end else if (cmd.d_next) begin
			d_q <= d_q + DW'(DIV_STEP);
		end

		if (cmd.sqrt_start) begin
			sv_q   <= SQW'(v_q);
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			sv_q <= sv_q << 2;
			if (sq_ge) begin
				srem_q <= sq_sh - sq_trial;
				root_q <= {root_q[HALF-2:0], 1'b1};
			end else begin
				srem_q <= sq_sh;
				root_q <= {root_q[HALF-2:0], 1'b0};
			end
		end

		if (cmd.div_start) begin
			dd_q  <= v_q;
			r_q   <= '0;
			dvs_q <= dsel;
		end else if (cmd.div_step) begin
			dd_q <= dd_q << 1;
			r_q  <= r_ge ? (r_sh - {1'b0, dvs_q}) : r_sh;
		end
	end

	assign sts.le1        = v_q <= W'(1);
	assign sts.le3        = v_q <= W'(SMALL_PRIME_MAX);
	assign sts.even       = ~v_q[0];
	assign sts.sqrt_last  = cnt_q == CW'(HALF - 1);
	assign sts.div_last   = cnt_q == CW'(W - 1);
	assign sts.rem_zero   = r_q == '0;
	assign sts.past_bound = (d_q - DW'(1)) > DW'(root_q);

	assign value = v_q;

	`PTDT_ASSERT_NXT(a_rem_below_divisor, clk, arst_n, cmd.div_step, r_q < {1'b0, dvs_q})
	`PTDT_ASSERT_NXT(a_root_fits_step, clk, arst_n, cmd.sqrt_start, root_q == '0)

endmodule

>>> hw/rtl/ptdt_ctrl.sv
`include "prime_trial_division_tester_unit_macros.svh"

module ptdt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_free,
	input  ptdt_pkg::ptdt_sts_t sts,
	output ptdt_pkg::ptdt_cmd_t cmd,
	output logic                in_ready,
	output logic                out_load,
	output logic                out_flag
);
	import ptdt_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CLASS  = 7'b0000010,
		ST_DIV    = 7'b0000100,
		ST_DIVCHK = 7'b0001000,
		ST_SQRT   = 7'b0010000,
		ST_LOOP   = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   res_q, res_d;
	logic   mod3_q, mod3_d;
	logic   second_q, second_d;

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		mod3_d   = mod3_q;
		second_d = second_q;
		cmd      = '0;
		cmd.div_sel = DS_D;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = ST_CLASS;
				end
			end
			ST_CLASS: begin
				if (sts.le1) begin
					res_d   = 1'b0;
					state_d = ST_FIN;
				end else if (sts.le3) begin
					res_d   = 1'b1;
					state_d = ST_FIN;
				end else if (sts.even) begin
					res_d   = 1'b0;
					state_d = ST_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_THREE;
					mod3_d        = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DIVCHK;
				end
			end
			ST_DIVCHK: begin
				if (sts.rem_zero) begin
					res_d   = 1'b0;
					state_d = ST_FIN;
				end else if (mod3_q) begin
					cmd.sqrt_start = 1'b1;
					mod3_d         = 1'b0;
					state_d        = ST_SQRT;
				end else if (!second_q) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_D2;
					second_d      = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.d_next = 1'b1;
					state_d    = ST_LOOP;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_last) begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.past_bound) begin
					res_d   = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_D;
					second_d      = 1'b0;
					state_d       = ST_DIV;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			res_q    <= 1'b0;
			mod3_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			res_q    <= res_d;
			mod3_q   <= mod3_d;
			second_q <= second_d;
		end
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_flag = res_q;

	`PTDT_ASSERT_NXT(a_divisor_hit_fails, clk, arst_n, (state_q == ST_DIVCHK) && sts.rem_zero, (state_q == ST_FIN) && !res_q)
	`PTDT_ASSERT_NXT(a_bound_passed_prime, clk, arst_n, (state_q == ST_LOOP) && sts.past_bound, (state_q == ST_FIN) && res_q)
	`PTDT_ASSERT_IMP(a_load_only_idle, clk, arst_n, out_load || cmd.load, (state_q == ST_FIN) || (state_q == ST_IDLE))

endmodule

>>> sim/testbench.sv
module testbench;
	import ptdt_pkg::*;

	localparam int VB           = VALUE_BITS_DEF;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int RANDOM_ITEMS = 78;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_PCT     = 15;
	localparam int NUM_VECTORS  = 22;

	typedef struct packed {
		logic [CAND_BITS-1:0] value;
		logic                 prime;
	} verdict_t;

	// typed = 1: the prime flag in the row is the expected answer
	typedef struct packed {
		logic [CAND_BITS-1:0] cand;
		logic                 typed;
		logic                 prime;
	} vector_t;

	localparam vector_t VECTORS [NUM_VECTORS] = '{
		'{32'd0,          1'b1, 1'b0},
		'{32'd1,          1'b1, 1'b0},
		'{32'd2,          1'b1, 1'b1},
		'{32'd3,          1'b1, 1'b1},
		'{32'd4,          1'b1, 1'b0},
		'{32'd5,          1'b1, 1'b1},
		'{32'd7,          1'b1, 1'b1},
		'{32'd9,          1'b1, 1'b0},
		'{32'd25,         1'b1, 1'b0},
		'{32'd49,         1'b1, 1'b0},
		'{32'd35,         1'b0, 1'b0},
		'{32'd121,        1'b0, 1'b0},
		'{32'd169,        1'b0, 1'b0},
		'{32'hFFFFFFFF,   1'b1, 1'b0},
		'{32'hFFFFFFFE,   1'b1, 1'b0},
		'{32'h80000000,   1'b1, 1'b0},
		'{32'hAAAAAAAA,   1'b1, 1'b0},
		'{32'h55555555,   1'b0, 1'b0},
		'{32'd65521,      1'b0, 1'b0},
		'{32'd65537,      1'b0, 1'b0},
		'{32'd1000003,    1'b0, 1'b0},
		'{32'd16744463,   1'b0, 1'b0}   // 4091 * 4093, long divisor walk
	};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [CAND_BITS-1:0] s_tdata  = '0;   // [31:0] candidate
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [CAND_BITS-1:0] m_tdata;         // [31:0] tested_value
	logic [0:0]           m_tuser;         // [0] prime_flag

	verdict_t pending[$];
	int       errors  = 0;
	int       results = 0;
	int       primes  = 0;
	int       cycles  = 0;
	bit       quiet   = 1'b0;   // no idling on either side while set

	prime_trial_division_tester_unit #(
		.VALUE_BITS(VB)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// digit-by-digit floor square root
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned place;
		root  = 0;
		place = 64'h4000_0000_0000_0000;
		while (place > v)
			place >>= 2;
		while (place != 0) begin
			if (v >= root + place) begin
				v    = v - (root + place);
				root = (root >> 1) + place;
			end else begin
				root >>= 1;
			end
			place >>= 2;
		end
		return root;
	endfunction

	function automatic verdict_t primality_of(input logic [CAND_BITS-1:0] c);
		longint unsigned v;
		longint unsigned lim;
		longint unsigned d;
		verdict_t        r;
		v = 64'(c);
		if (VB < 64)
			v = v & ((64'd1 << VB) - 1);
		r.value = v[CAND_BITS-1:0];
		if (v <= 1) begin
			r.prime = 1'b0;
		end else if (v <= SMALL_PRIME_MAX) begin
			r.prime = 1'b1;
		end else if (v % 2 == 0 || v % 3 == 0) begin
			r.prime = 1'b0;
		end else begin
			r.prime = 1'b1;
			lim = floor_sqrt(v);
			for (d = 64'(FIRST_DIV); d - 1 <= lim; d += DIV_STEP) begin
				if (v % d == 0 || v % (d + PAIR_GAP) == 0) begin
					r.prime = 1'b0;
					break;
				end
			end
		end
		return r;
	endfunction

	// mostly small values; full-width ones carry a small factor so they finish fast
	function automatic logic [CAND_BITS-1:0] random_candidate();
		int          pick;
		logic [31:0] k;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return $urandom_range(0, 4095);
		if (pick < 65)
			return $urandom_range(0, 32'h000F_FFFF);
		if (pick < 90) begin
			k = 5 + 2 * $urandom_range(0, 10);
			return $urandom_range(0, 32'hFFFF_FFFF / k) * k;
		end
		return $urandom_range(0, 32'h5555_5555) * 3;
	endfunction

	task automatic offer(input logic [CAND_BITS-1:0] c, input logic typed, input logic flag);
		verdict_t v;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		v = primality_of(c);
		if (typed)
			v.prime = flag;
		pending.push_back(v);
	endtask

	// result side: checks and back-pressure
	initial begin
		int       hold;
		bit       held;
		verdict_t want;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				results++;
				if (m_tuser[0])
					primes++;
				if (pending.size() == 0) begin
					$error("unexpected item: tested_value %h prime_flag %b", m_tdata, m_tuser[0]);
					errors++;
				end else begin
					want = pending.pop_front();
					if (m_tdata !== want.value) begin
						$error("tested_value: expected %h, actual %h", want.value, m_tdata);
						errors++;
					end
					if (m_tuser[0] !== want.prime) begin
						$error("prime_flag: expected %b, actual %b (value %h)",
							want.prime, m_tuser[0], want.value);
						errors++;
					end
				end
				// long stall so the unit fills and drops s_tready
				if (results == 30 && !held) begin
					held = 1'b1;
					hold = HOLD_CYCLES;
				end
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d items still outstanding", cycles, pending.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		vector_t row;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (VECTORS[i]) begin
			row = VECTORS[i];
			offer(row.cand, row.typed, row.prime);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 40 && n < 70);
			if (n == 70) begin
				// drain completely before going on
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending.size() != 0);
			end
			offer(random_candidate(), 1'b0, 1'b0);
		end
		s_tvalid <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d directed and %0d random candidates, %0d results checked, %0d prime",
			NUM_VECTORS, RANDOM_ITEMS, results, primes);
		$display("small values, full-width extremes, prime squares, a %0d-cycle stall, a drain",
			HOLD_CYCLES);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
